### hw/rtl/fuot_pkg.sv
package fuot_pkg;

	// default table size
	localparam int MAX_ENTRIES_DEF = 8;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

	// configuration register reset values
	localparam logic [7:0] UNIT_KIND_RST = 8'd0;
	localparam logic [7:0] LATENCY_RST   = 8'd1;
	localparam logic [3:0] CAPACITY_RST  = 4'd8;

	// register indexes on the configuration port
	localparam logic [1:0] REG_UNIT_KIND = 2'd0;
	localparam logic [1:0] REG_LATENCY   = 2'd1;
	localparam logic [1:0] REG_CAPACITY  = 2'd2;

	typedef enum logic [1:0] {
		OP_OFFER  = 2'd0,
		OP_TICK   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RPL_OFFER  = 2'd0,
		RPL_TICK   = 2'd1,
		RPL_REMOVE = 2'd2
	} reply_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SCAN,
		BS_FIN
	} bstate_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t         op;
		logic [15:0] tag;
		logic        offer_ok;
		logic [31:0] cycle;
	} word_t;

	// one result word
	typedef struct packed {
		reply_t      reply_kind;
		logic        accepted;
		logic        has_completion;
		logic [15:0] done_tag;
		logic [31:0] done_cycle;
		logic [3:0]  occupancy;
		logic        full_res;
		logic        last;
	} res_t;

endpackage

### hw/rtl/functional_unit_occupancy_tracker.sv
// Channel  | Direction | Handshake                        | Word
// ---------+-----------+----------------------------------+------------------------------------
// command  | in        | start high, busy low             | op, tag, inst_kind, already_issued,
//          |           |                                  | cycle
// result   | out       | strobe high for one cycle        | reply_kind, accepted, has_completion,
//          |           |                                  | done_tag, done_cycle, occupancy,
//          |           |                                  | full_res, last
// config   | in        | APB write, psel penable pwrite   | paddr, pwdata; prdata on read
//
// An offer is settled in the execution side as it is popped, and its reply passes from the
// taken command through the front register, the queue and the result register.
// A tick or remove goes through the execution side in order: the pop, a scan that rotates
// every table slot past the head, and a closing state.
// busy rises only when the two-word queue and the front register are both full.
// Reset empties the table and the queue and restores the registers to their defaults.
// Results leave at most one per cycle; the receiver cannot stall them.
module functional_unit_occupancy_tracker #(
	parameter int MAX_ENTRIES = fuot_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [15:0]       tag,
	input  logic signed [7:0] inst_kind,
	input  logic              already_issued,
	input  logic [31:0]       cycle,
	output logic              strobe,
	output logic [1:0]        reply_kind,
	output logic              accepted,
	output logic              has_completion,
	output logic [15:0]       done_tag,
	output logic [31:0]       done_cycle,
	output logic [3:0]        occupancy,
	output logic              full_res,
	output logic              last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import fuot_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = (CNT_W > 4) ? CNT_W : 4;

	logic [7:0]       unit_kind_q;
	logic [7:0]       latency_q;
	logic [3:0]       capacity_q;
	logic [EW-1:0]    cap_ext;
	logic [EW-1:0]    eff_ext;
	logic [CNT_W-1:0] eff_cap;
	logic             cfg_wr;

	logic             f_valid;
	logic             f_ready;
	word_t            f_word;
	logic             b_valid;
	logic             b_ready;
	word_t            b_word;
	logic             r_valid;
	res_t             r_word;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_kind_q <= UNIT_KIND_RST;
			latency_q   <= LATENCY_RST;
			capacity_q  <= CAPACITY_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_UNIT_KIND: unit_kind_q <= pwdata[7:0];
				REG_LATENCY:   latency_q   <= pwdata[7:0];
				REG_CAPACITY:  capacity_q  <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_UNIT_KIND: prdata = {24'd0, unit_kind_q};
			REG_LATENCY:   prdata = {24'd0, latency_q};
			REG_CAPACITY:  prdata = {28'd0, capacity_q};
			default:       prdata = 32'd0;
		endcase
	end

	// clamp the usable capacity to the table size
	assign cap_ext = EW'(capacity_q);
	assign eff_ext = (cap_ext > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_ext;
	assign eff_cap = CNT_W'(eff_ext);

	fuot_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.tag            (tag),
		.inst_kind      (inst_kind),
		.already_issued (already_issued),
		.cycle          (cycle),
		.unit_kind      (unit_kind_q),
		.push_valid     (f_valid),
		.push_ready     (f_ready),
		.push_word      (f_word)
	);

	fuot_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_word  (f_word),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_word   (b_word)
	);

	fuot_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_word  (b_word),
		.latency   (latency_q),
		.eff_cap   (eff_cap),
		.res_valid (r_valid),
		.res       (r_word)
	);

	// unpack the result word
	assign strobe         = r_valid;
	assign reply_kind     = r_word.reply_kind;
	assign accepted       = r_word.accepted;
	assign has_completion = r_word.has_completion;
	assign done_tag       = r_word.done_tag;
	assign done_cycle     = r_word.done_cycle;
	assign occupancy      = r_word.occupancy;
	assign full_res       = r_word.full_res;
	assign last           = r_word.last;

	// offer and remove replies are single words
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (reply_kind != RPL_TICK) |-> last)
		else $error("non-tick reply without last");

	// only tick reports name a finished instruction
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && has_completion |-> (reply_kind == RPL_TICK) && !accepted)
		else $error("completion outside a tick report");

	// a report without completion carries no tag or cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !has_completion |-> (done_tag == 16'd0) && (done_cycle == 32'd0))
		else $error("stray completion payload");

	// busy only while the front holds a word the queue refuses
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> f_valid && !f_ready)
		else $error("busy without a held word");

endmodule

### hw/rtl/fuot_front.sv
module fuot_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [15:0]       tag,
	input  logic signed [7:0] inst_kind,
	input  logic              already_issued,
	input  logic [31:0]       cycle,
	input  logic [7:0]        unit_kind,
	output logic              push_valid,
	input  logic              push_ready,
	output fuot_pkg::word_t   push_word
);
	import fuot_pkg::*;

	logic        valid_s1;
	word_t       word_s1;
	logic        accept;
	logic        known;
	logic [8:0]  kind_mag;
	word_t       word_d;

	assign busy       = valid_s1 && !push_ready;
	assign accept     = start && !busy;
	assign push_valid = valid_s1;
	assign push_word  = word_s1;

	// take the magnitude of the signed kind; minus 128 gives 128
	assign kind_mag = inst_kind[7] ? (9'd256 - {1'b0, inst_kind}) : {1'b0, inst_kind};

	// classify the incoming word; the unused op code is dropped here
	always_comb begin
		word_d.op       = OP_OFFER;
		word_d.tag      = tag;
		word_d.offer_ok = (kind_mag == {1'b0, unit_kind}) && !already_issued;
		word_d.cycle    = cycle;
		known           = 1'b0;
		unique case (op)
			OP_OFFER: begin
				word_d.op = OP_OFFER;
				known     = 1'b1;
			end
			OP_TICK: begin
				word_d.op = OP_TICK;
				known     = 1'b1;
			end
			OP_REMOVE: begin
				word_d.op = OP_REMOVE;
				known     = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (valid_s1 && push_ready) begin
				valid_s1 <= 1'b0;
			end
			if (accept && known) begin
				valid_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && known) begin
			word_s1 <= word_d;
		end
	end

endmodule

### hw/rtl/fuot_queue.sv
module fuot_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  fuot_pkg::word_t push_word,
	output logic            pop_valid,
	input  logic            pop_ready,
	output fuot_pkg::word_t pop_word
);
	import fuot_pkg::*;

	localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QC_W = $clog2(QDEPTH + 1);

	word_t           slot_q [QDEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QC_W-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = fill_q < QC_W'(QDEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_word   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QA_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_word;
		end
	end

endmodule

### hw/rtl/fuot_back.sv
module fuot_back #(
	parameter int MAX_ENTRIES = fuot_pkg::MAX_ENTRIES_DEF,
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  fuot_pkg::word_t   pop_word,
	input  logic [7:0]        latency,
	input  logic [CNT_W-1:0]  eff_cap,
	output logic              res_valid,
	output fuot_pkg::res_t    res
);
	import fuot_pkg::*;

	bstate_t          state_q;
	bstate_t          state_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] pos_q;
	op_t              cur_op_q;
	logic [15:0]      cur_tag_q;
	logic [31:0]      cur_cycle_q;
	logic             found_q;
	logic             pend_q;
	logic [15:0]      pend_tag_q;

	logic [15:0]      tag_q [MAX_ENTRIES];
	logic [7:0]       rem_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] done_q;

	res_t             res_q;
	logic             res_valid_q;
	res_t             res_d;
	logic             emit;

	logic             pop;
	logic             offer_take;
	logic             live;
	logic             is_tick;
	logic [7:0]       rem_dec;
	logic [7:0]       head_rem_new;
	logic             newly;
	logic             match;
	logic             scan_end;
	logic             shrink;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// look at the table head; the scan rotates the whole table once
	assign live         = k_q < count_q;
	assign is_tick      = cur_op_q == OP_TICK;
	assign rem_dec      = (rem_q[0] != 8'd0) ? rem_q[0] - 8'd1 : rem_q[0];
	assign head_rem_new = (is_tick && live) ? rem_dec : rem_q[0];
	assign newly        = is_tick && live && (rem_dec == 8'd0) && !done_q[0];
	assign match        = !is_tick && live && !found_q && (tag_q[0] == cur_tag_q);
	assign scan_end     = k_q == CNT_W'(MAX_ENTRIES - 1);

	// next state, queue pop and result word
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		offer_take = 1'b0;
		shrink     = 1'b0;
		emit       = 1'b0;
		count_d    = count_q;
		res_d.reply_kind     = RPL_TICK;
		res_d.accepted       = 1'b0;
		res_d.has_completion = 1'b0;
		res_d.done_tag       = 16'd0;
		res_d.done_cycle     = 32'd0;
		res_d.last           = 1'b1;
		unique case (state_q)
			BS_IDLE: begin
				pop = pop_valid;
				if (pop_valid) begin
					unique case (pop_word.op)
						OP_OFFER: begin
							offer_take = pop_word.offer_ok && (count_q < eff_cap);
							if (offer_take) begin
								count_d = count_q + 1'b1;
							end
							emit             = 1'b1;
							res_d.reply_kind = RPL_OFFER;
							res_d.accepted   = offer_take;
						end
						OP_TICK, OP_REMOVE: begin
							state_d = BS_SCAN;
						end
						default: begin
							state_d = BS_IDLE;
						end
					endcase
				end
			end
			BS_SCAN: begin
				// a new completion releases the one held before it
				if (newly && pend_q) begin
					emit                 = 1'b1;
					res_d.has_completion = 1'b1;
					res_d.done_tag       = pend_tag_q;
					res_d.done_cycle     = cur_cycle_q;
					res_d.last           = 1'b0;
				end
				if (scan_end) begin
					state_d = BS_FIN;
				end
			end
			BS_FIN: begin
				emit = 1'b1;
				if (is_tick) begin
					if (pend_q) begin
						res_d.has_completion = 1'b1;
						res_d.done_tag       = pend_tag_q;
						res_d.done_cycle     = cur_cycle_q;
					end
				end else begin
					res_d.reply_kind = RPL_REMOVE;
					res_d.accepted   = found_q;
					shrink           = found_q;
					if (found_q) begin
						count_d = count_q - 1'b1;
					end
				end
				state_d = BS_IDLE;
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
		res_d.occupancy = 4'(count_d);
		res_d.full_res  = count_d >= eff_cap;
	end

	assign pop_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
			count_q     <= count_d;
			if (pop) begin
				k_q     <= '0;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
			end else if (state_q == BS_SCAN) begin
				k_q <= k_q + 1'b1;
				if (newly) begin
					pend_q <= 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// done bits: clear on append, rotate on scan, close the gap on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else begin
			if (offer_take) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (CNT_W'(j) == count_q) begin
						done_q[j] <= 1'b0;
					end
				end
			end else if (state_q == BS_SCAN) begin
				for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
					done_q[j] <= done_q[j+1];
				end
				done_q[MAX_ENTRIES-1] <= done_q[0] || newly;
			end else if (shrink) begin
				for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
					if (CNT_W'(j) >= pos_q) begin
						done_q[j] <= done_q[j+1];
					end
				end
			end
		end
	end

	// tags and countdowns follow the same moves
	always_ff @(posedge clk) begin
		if (offer_take) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (CNT_W'(j) == count_q) begin
					tag_q[j] <= pop_word.tag;
					rem_q[j] <= latency;
				end
			end
		end else if (state_q == BS_SCAN) begin
			for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
				tag_q[j] <= tag_q[j+1];
				rem_q[j] <= rem_q[j+1];
			end
			tag_q[MAX_ENTRIES-1] <= tag_q[0];
			rem_q[MAX_ENTRIES-1] <= head_rem_new;
		end else if (shrink) begin
			for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
				if (CNT_W'(j) >= pos_q) begin
					tag_q[j] <= tag_q[j+1];
					rem_q[j] <= rem_q[j+1];
				end
			end
		end
	end

	// latch the current word and scan marks
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_op_q    <= pop_word.op;
			cur_tag_q   <= pop_word.tag;
			cur_cycle_q <= pop_word.cycle;
		end
		if (state_q == BS_SCAN && newly) begin
			pend_tag_q <= tag_q[0];
		end
		if (state_q == BS_SCAN && match) begin
			pos_q <= k_q;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

endmodule

### test/tb_functional_unit_occupancy_tracker.sv
`timescale 1ns / 100ps

module tb_functional_unit_occupancy_tracker;
	import fuot_pkg::*;

	localparam int TBL_SIZE = MAX_ENTRIES_DEF;
	// drain time once the last reply is in: a full table scan plus the pipe
	localparam int SETTLE = 2 * (TBL_SIZE + 2) + 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_WORDS = 36;
	localparam int NUM_PHASES = 8;

	typedef struct {
		logic        is_cfg;
		logic [1:0]  reg_idx;
		logic [7:0]  reg_val;
		logic [1:0]  op;
		logic [15:0] tag;
		logic [7:0]  kind;
		logic        iss;
		logic [31:0] cyc;
		logic        known;
		logic        exp_acc;
		logic [3:0]  exp_occ;
		logic        exp_full;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        op;
	logic [15:0]       tag;
	logic signed [7:0] inst_kind;
	logic              already_issued;
	logic [31:0]       cycle;
	logic              strobe;
	logic [1:0]        reply_kind;
	logic              accepted;
	logic              has_completion;
	logic [15:0]       done_tag;
	logic [31:0]       done_cycle;
	logic [3:0]        occupancy;
	logic              full_res;
	logic              last;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// shadow of the unit: configuration and in-flight table
	logic [7:0]  cfg_kind;
	logic [7:0]  cfg_lat;
	logic [3:0]  cfg_cap;
	logic [15:0] tbl_tag [TBL_SIZE];
	logic [7:0]  tbl_left [TBL_SIZE];
	logic        tbl_done [TBL_SIZE];
	int          tbl_cnt;

	res_t due_replies[$];
	int   mismatches;
	int   burst_left;

	functional_unit_occupancy_tracker dut (.*);

	always #10 clk = ~clk;

	// one reply word as the unit would build it from the current table
	function automatic res_t make_reply(reply_t k, logic acc, logic has, logic [15:0] t,
			logic [31:0] c, logic lst);
		res_t r;
		int eff_cap;
		eff_cap = (cfg_cap > TBL_SIZE) ? TBL_SIZE : cfg_cap;
		r.reply_kind     = k;
		r.accepted       = acc;
		r.has_completion = has;
		r.done_tag       = t;
		r.done_cycle     = c;
		r.occupancy      = tbl_cnt[3:0];
		r.full_res       = (tbl_cnt >= eff_cap);
		r.last           = lst;
		return r;
	endfunction

	// apply one accepted word to the table and queue the replies it causes
	function automatic void advance_table(logic [1:0] o, logic [15:0] t, logic [7:0] kb,
			logic iss, logic [31:0] c);
		int mag;
		int eff_cap;
		int i;
		int hit;
		int fin[$];
		eff_cap = (cfg_cap > TBL_SIZE) ? TBL_SIZE : cfg_cap;
		case (o)
		OP_OFFER: begin
			mag = kb[7] ? (256 - int'(kb)) : int'(kb);
			if (mag == int'(cfg_kind) && tbl_cnt < eff_cap && !iss) begin
				tbl_tag[tbl_cnt]  = t;
				tbl_left[tbl_cnt] = cfg_lat;
				tbl_done[tbl_cnt] = 1'b0;
				tbl_cnt++;
				due_replies.insert(due_replies.size(),
					make_reply(RPL_OFFER, 1'b1, 1'b0, '0, '0, 1'b1));
			end else begin
				due_replies.insert(due_replies.size(),
					make_reply(RPL_OFFER, 1'b0, 1'b0, '0, '0, 1'b1));
			end
		end
		OP_TICK: begin
			for (i = 0; i < tbl_cnt; i++) begin
				if (tbl_left[i] != 0)
					tbl_left[i]--;
				if (tbl_left[i] == 0 && !tbl_done[i]) begin
					tbl_done[i] = 1'b1;
					fin.insert(fin.size(), i);
				end
			end
			if (fin.size() == 0)
				due_replies.insert(due_replies.size(),
					make_reply(RPL_TICK, 1'b0, 1'b0, '0, '0, 1'b1));
			for (i = 0; i < fin.size(); i++)
				due_replies.insert(due_replies.size(),
					make_reply(RPL_TICK, 1'b0, 1'b1, tbl_tag[fin[i]], c,
					i == fin.size() - 1));
		end
		OP_REMOVE: begin
			hit = -1;
			for (i = 0; i < tbl_cnt; i++)
				if (hit < 0 && tbl_tag[i] == t)
					hit = i;
			// close the gap behind the removed entry
			if (hit >= 0) begin
				for (i = hit + 1; i < tbl_cnt; i++) begin
					tbl_tag[i-1]  = tbl_tag[i];
					tbl_left[i-1] = tbl_left[i];
					tbl_done[i-1] = tbl_done[i];
				end
				tbl_cnt--;
			end
			due_replies.insert(due_replies.size(),
				make_reply(RPL_REMOVE, hit >= 0, 1'b0, '0, '0, 1'b1));
		end
		default: ;
		endcase
	endfunction

	function automatic stim_row_t cmd_row(logic [1:0] o, logic [15:0] t, logic [7:0] kb,
			logic iss, logic [31:0] c);
		stim_row_t r;
		r = '{default: '0};
		r.op   = o;
		r.tag  = t;
		r.kind = kb;
		r.iss  = iss;
		r.cyc  = c;
		return r;
	endfunction

	function automatic stim_row_t known_row(logic [1:0] o, logic [15:0] t, logic [7:0] kb,
			logic iss, logic [31:0] c, logic acc, logic [3:0] occ, logic full);
		stim_row_t r;
		r = cmd_row(o, t, kb, iss, c);
		r.known    = 1'b1;
		r.exp_acc  = acc;
		r.exp_occ  = occ;
		r.exp_full = full;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [1:0] idx, logic [7:0] val);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// drop start, then hold until every reply is in and the unit has drained
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		wait_idle();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		REG_UNIT_KIND: cfg_kind = val;
		REG_LATENCY:   cfg_lat = val;
		REG_CAPACITY:  cfg_cap = val[3:0];
		default: ;
		endcase
	endtask

	// bursts of back-to-back words separated by random gaps, which may be empty
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = int'($urandom_range(1, 16));
			gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		burst_left--;
	endtask

	// present one command word and hold it until the unit takes it
	task automatic send_word(stim_row_t r);
		res_t fix;
		@(negedge clk);
		start          <= 1'b1;
		op             <= r.op;
		tag            <= r.tag;
		inst_kind      <= r.kind;
		already_issued <= r.iss;
		cycle          <= r.cyc;
		do @(posedge clk); while (busy);
		if (r.op != OP_UNUSED) begin
			advance_table(r.op, r.tag, r.kind, r.iss, r.cyc);
			if (r.known) begin
				fix = due_replies[due_replies.size() - 1];
				fix.accepted  = r.exp_acc;
				fix.occupancy = r.exp_occ;
				fix.full_res  = r.exp_full;
				due_replies[due_replies.size() - 1] = fix;
			end
		end
	endtask

	// check each reply word against the oldest one due
	always @(posedge clk) begin : chk_replies
		res_t want;
		if (arst_n && strobe) begin
			if (due_replies.size() == 0) begin
				$error("reply word with none due: reply_kind %0d", reply_kind);
				mismatches++;
			end else begin
				want = due_replies.pop_front();
				cmp_field("reply_kind", 32'(want.reply_kind), 32'(reply_kind));
				cmp_field("accepted", 32'(want.accepted), 32'(accepted));
				cmp_field("has_completion", 32'(want.has_completion),
					32'(has_completion));
				cmp_field("done_tag", 32'(want.done_tag), 32'(done_tag));
				cmp_field("done_cycle", want.done_cycle, done_cycle);
				cmp_field("occupancy", 32'(want.occupancy), 32'(occupancy));
				cmp_field("full_res", 32'(want.full_res), 32'(full_res));
				cmp_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	initial begin : watchdog
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : main_seq
		stim_row_t plan[$];
		stim_row_t r;
		int i;
		int ph;
		int n;
		int sel;
		logic [31:0] tick_cyc;
		logic [7:0] k_val;
		logic [7:0] l_val;
		logic [3:0] c_val;

		arst_n         = 1'b0;
		start          = 1'b0;
		op             = OP_OFFER;
		tag            = '0;
		inst_kind      = '0;
		already_issued = 1'b0;
		cycle          = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		cfg_kind       = UNIT_KIND_RST;
		cfg_lat        = LATENCY_RST;
		cfg_cap        = CAPACITY_RST;
		tbl_cnt        = 0;
		mismatches     = 0;
		burst_left     = 0;
		tick_cyc       = 32'd100;
		for (i = 0; i < TBL_SIZE; i++) begin
			tbl_tag[i]  = '0;
			tbl_left[i] = '0;
			tbl_done[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults after reset: kind 0, full capacity
		plan.insert(plan.size(),
			known_row(OP_TICK, 16'h0000, 8'h00, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'hFFFF, 8'h00, 1'b0, 32'h0, 1'b1, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0000, 8'h00, 1'b1, 32'h0, 1'b0, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0001, 8'h01, 1'b0, 32'h0, 1'b0, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h1234, 8'h00, 1'b0, 32'h0, 1'b1, 4'd2, 1'b0));
		// both finish on cycle zero, then must not be reported again
		plan.insert(plan.size(), cmd_row(OP_TICK, 16'h0000, 8'h00, 1'b0, 32'h0));
		plan.insert(plan.size(),
			known_row(OP_TICK, 16'h0, 8'h00, 1'b0, 32'hFFFFFFFF, 1'b0, 4'd2, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_REMOVE, 16'hABCD, 8'h00, 1'b0, 32'h0, 1'b0, 4'd2, 1'b0));
		plan.insert(plan.size(), cmd_row(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF));
		plan.insert(plan.size(),
			known_row(OP_REMOVE, 16'hFFFF, 8'h00, 1'b0, 32'h0, 1'b1, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_REMOVE, 16'h1234, 8'h00, 1'b0, 32'h0, 1'b1, 4'd0, 1'b0));
		// kind minus 128, capacity two, duplicate tags
		plan.insert(plan.size(), cfg_row(REG_UNIT_KIND, 8'd128));
		plan.insert(plan.size(), cfg_row(REG_LATENCY, 8'd0));
		plan.insert(plan.size(), cfg_row(REG_CAPACITY, 8'd2));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0005, 8'h80, 1'b0, 32'h0, 1'b1, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0006, 8'h7F, 1'b0, 32'h0, 1'b0, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0005, 8'h80, 1'b0, 32'h0, 1'b1, 4'd2, 1'b1));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0006, 8'h80, 1'b0, 32'h0, 1'b0, 4'd2, 1'b1));
		plan.insert(plan.size(), cmd_row(OP_TICK, 16'h0000, 8'h00, 1'b0, 32'h80000000));
		plan.insert(plan.size(),
			known_row(OP_REMOVE, 16'h0005, 8'h00, 1'b0, 32'h0, 1'b1, 4'd1, 1'b0));
		plan.insert(plan.size(),
			known_row(OP_REMOVE, 16'h0005, 8'h00, 1'b0, 32'h0, 1'b1, 4'd0, 1'b0));
		// capacity zero: always full
		plan.insert(plan.size(), cfg_row(REG_UNIT_KIND, 8'd0));
		plan.insert(plan.size(), cfg_row(REG_LATENCY, 8'd255));
		plan.insert(plan.size(), cfg_row(REG_CAPACITY, 8'd0));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0007, 8'h00, 1'b0, 32'h0, 1'b0, 4'd0, 1'b1));
		// capacity above table size: fill all entries, then one more
		plan.insert(plan.size(), cfg_row(REG_UNIT_KIND, 8'd1));
		plan.insert(plan.size(), cfg_row(REG_CAPACITY, 8'd15));
		for (i = 0; i < TBL_SIZE; i++)
			plan.insert(plan.size(),
				known_row(OP_OFFER, 16'h0100 + i[15:0], i[0] ? 8'hFF : 8'h01,
				1'b0, 32'h0, 1'b1, i[3:0] + 4'd1, i == TBL_SIZE - 1));
		plan.insert(plan.size(),
			known_row(OP_OFFER, 16'h0200, 8'hFF, 1'b0, 32'h0, 1'b0, 4'd8, 1'b1));

		foreach (plan[j]) begin
			if (plan[j].is_cfg) begin
				write_reg(plan[j].reg_idx, plan[j].reg_val);
			end else begin
				pace();
				send_word(plan[j]);
			end
		end

		// random phases, each under its own setting
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
			0: begin
				k_val = 8'($urandom_range(0, 128));
				l_val = 8'd0;
				c_val = 4'd8;
			end
			1: begin
				k_val = 8'd128;
				l_val = 8'd255;
				c_val = 4'd1;
			end
			2: begin
				k_val = 8'd255;
				l_val = 8'd2;
				c_val = 4'd15;
			end
			default: begin
				k_val = 8'($urandom_range(0, 128));
				l_val = 8'($urandom_range(0, 4));
				c_val = 4'($urandom_range(1, 8));
			end
			endcase
			write_reg(REG_UNIT_KIND, k_val);
			write_reg(REG_LATENCY, l_val);
			write_reg(REG_CAPACITY, {4'h0, c_val});
			n = 0;
			while (n < PHASE_WORDS) begin
				sel = int'($urandom_range(0, 99));
				r = cmd_row(OP_OFFER, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, $urandom());
				if (sel < 3) begin
					r.op = OP_UNUSED;
				end else if (sel < 48) begin
					// mostly a matching kind of either sign, some reused tags
					if (cfg_kind <= 8'd128 && $urandom_range(0, 4) != 0)
						r.kind = $urandom_range(0, 1) ? (8'd0 - cfg_kind) : cfg_kind;
					if ($urandom_range(0, 1))
						r.tag = 16'($urandom_range(0, 7));
				end else if (sel < 82) begin
					r.op = OP_TICK;
					tick_cyc = tick_cyc + $urandom_range(1, 3);
					if ($urandom_range(0, 9) != 0)
						r.cyc = tick_cyc;
				end else begin
					r.op = OP_REMOVE;
					if (tbl_cnt > 0 && $urandom_range(0, 4) != 0)
						r.tag = tbl_tag[$urandom_range(0, tbl_cnt - 1)];
				end
				pace();
				send_word(r);
				if (r.op != OP_UNUSED)
					n++;
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
